### hw/rtl/dominated_vector_pruner_macros.svh
// Assertion helpers for the pruner. Clock clk, reset arst_n (active low).
`ifndef DOMINATED_VECTOR_PRUNER_MACROS_SVH
`define DOMINATED_VECTOR_PRUNER_MACROS_SVH

// same-cycle implication
`define DVP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DVP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dvp_pkg.sv
`default_nettype none
package dvp_pkg;

	localparam int MAX_VECTORS    = 16;
	localparam int MAX_COMPONENTS = 4;

	localparam int VALUE_W = 32;
	localparam int CFG_W   = 3;
	localparam int VI_W    = 4;

	localparam int IDX_W    = $clog2(MAX_VECTORS);
	localparam int CNT_W    = $clog2(MAX_VECTORS + 1);
	localparam int CMP_W    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int KC_W     = ((CMP_W > CFG_W) ? CMP_W : CFG_W) + 1;
	localparam int ST_DEPTH = MAX_VECTORS * MAX_COMPONENTS;
	localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_POS,
		ST_SCAN,
		ST_READ,
		ST_CMP,
		ST_SWAP,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

### hw/rtl/dvp_if.sv
`default_nettype none
interface dvp_in_if import dvp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last_in_set;

	modport source (output valid, output value, output last_in_set, input ready);
	modport sink   (input valid, input value, input last_in_set, output ready);
endinterface

interface dvp_out_if import dvp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [VI_W-1:0] vector_index;
	logic            last;
	logic            overflow;

	modport source (output valid, output vector_index, output last, output overflow,
		input ready);
	modport sink   (input valid, input vector_index, input last, input overflow,
		output ready);
endinterface
`default_nettype wire

### hw/rtl/dominated_vector_pruner.sv
// Loading: one component per cycle; items.ready is high while loading.
// Pruning: a slot visit starts in ST_POS; ST_SCAN fetches each other slot and steps over
// the slot itself; each pair passes ST_READ and ST_CMP per component, and a swap ST_SWAP.
// Emission: one survivor per cycle through the output register, as results.ready allows.
// Reset (arst_n low): counters, flags, state and output valid clear; comp_q = 4.
// Store and slot list are not cleared; slot list entries are written before being read.
`default_nettype none
module dominated_vector_pruner import dvp_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [CFG_W-1:0]  cfg_wdata,
	dvp_in_if.sink           items,
	dvp_out_if.source        results
);

`include "dominated_vector_pruner_macros.svh"

	// Vector store: MAX_VECTORS x MAX_COMPONENTS words, two registered read ports.
	logic signed [VALUE_W-1:0] store_mem [ST_DEPTH];
	// Slot list: flops, one read address per cycle.
	logic [IDX_W-1:0]          slot_q [MAX_VECTORS];

	state_t state_q, state_d;

	logic [CFG_W-1:0] comp_q;
	logic [CNT_W-1:0] vl_q;
	logic [CMP_W-1:0] cp_q;
	logic             ov_q;

	// prune sequencer
	logic [CNT_W-1:0] live_q, pos_q, i_q, e_q;
	logic [CMP_W-1:0] c_q;
	logic [IDX_W-1:0] posv_q, aiv_q;
	logic signed [VALUE_W-1:0] rda_q, rdb_q;

	// output register
	logic            ovalid_q;
	logic [VI_W-1:0] vi_q;
	logic            olast_q;
	logic            oovf_q;

	logic [CFG_W-1:0] k_act;
	logic             acc, vec_done, room, last_comp, fail, take, emit_last;
	logic [CNT_W-1:0] vl_new;
	logic             ov_new;
	logic [IDX_W-1:0] slot_ra, slot_rd;
	logic [ST_AW-1:0] st_wa, st_ra, st_rb;
	logic             pruning;

	// Count clamp: zero acts as one, anything above the store width as the maximum.
	always_comb begin
		if (comp_q == '0) begin
			k_act = CFG_W'(1);
		end else if (int'(comp_q) > MAX_COMPONENTS) begin
			k_act = CFG_W'(MAX_COMPONENTS);
		end else begin
			k_act = comp_q;
		end
	end

	assign acc       = items.valid && items.ready;
	assign vec_done  = (KC_W'(cp_q) + KC_W'(1)) >= KC_W'(k_act);
	assign room      = vl_q < CNT_W'(MAX_VECTORS);
	assign vl_new    = vl_q + CNT_W'(vec_done && room);
	assign ov_new    = ov_q | (vec_done && !room);
	assign last_comp = (KC_W'(c_q) + KC_W'(1)) >= KC_W'(k_act);
	// candidate fails to cover the examined vector in this component
	assign fail      = rdb_q > rda_q;
	assign take      = (state_q == ST_EMIT) && (!ovalid_q || results.ready);
	assign emit_last = (e_q + CNT_W'(1)) == live_q;
	assign pruning   = (state_q != ST_LOAD) && (state_q != ST_EMIT);

	assign st_wa = ST_AW'(vl_q[IDX_W-1:0]) * ST_AW'(MAX_COMPONENTS) + ST_AW'(cp_q);
	assign st_ra = ST_AW'(aiv_q) * ST_AW'(MAX_COMPONENTS) + ST_AW'(c_q);
	assign st_rb = ST_AW'(posv_q) * ST_AW'(MAX_COMPONENTS) + ST_AW'(c_q);

	// single slot-list read port, address picked by the sequencer
	always_comb begin
		case (state_q)
			ST_POS:  slot_ra = pos_q[IDX_W-1:0];
			ST_SCAN: slot_ra = i_q[IDX_W-1:0];
			ST_SWAP: slot_ra = live_q[IDX_W-1:0];
			ST_EMIT: slot_ra = e_q[IDX_W-1:0];
			default: slot_ra = pos_q[IDX_W-1:0];
		endcase
	end
	assign slot_rd = slot_q[slot_ra];

	assign items.ready          = (state_q == ST_LOAD);
	assign results.valid        = ovalid_q;
	assign results.vector_index = vi_q;
	assign results.last         = olast_q;
	assign results.overflow     = oovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: each slot is checked against every other live slot; a covered
	// slot is swapped out to the end and the same slot is checked again.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (acc && items.last_in_set) begin
					if (vl_new == '0) begin
						state_d = ST_LOAD;
					end else if (vl_new < CNT_W'(2)) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_POS;
					end
				end
			end
			ST_POS: begin
				state_d = (pos_q >= live_q) ? ST_EMIT : ST_SCAN;
			end
			ST_SCAN: begin
				if (i_q >= live_q) begin
					state_d = ST_POS;
				end else if (i_q != pos_q) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_CMP;
			ST_CMP: begin
				if (fail) begin
					state_d = ST_SCAN;
				end else if (last_comp) begin
					state_d = ST_SWAP;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_SWAP: state_d = ST_POS;
			ST_EMIT: begin
				if (take && emit_last) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q   <= CFG_RESET;
			vl_q     <= '0;
			cp_q     <= '0;
			ov_q     <= 1'b0;
			live_q   <= '0;
			pos_q    <= '0;
			i_q      <= '0;
			e_q      <= '0;
			c_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				comp_q <= cfg_wdata;
			end
			ovalid_q <= take ? 1'b1 : (ovalid_q && !results.ready);
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						// empty set: nothing reported, flag dropped
						ov_q <= (items.last_in_set && vl_new == '0) ? 1'b0 : ov_new;
						if (items.last_in_set) begin
							vl_q   <= '0;
							cp_q   <= '0;
							live_q <= vl_new;
							pos_q  <= '0;
							e_q    <= '0;
						end else begin
							cp_q <= vec_done ? '0 : cp_q + CMP_W'(1);
							vl_q <= vl_new;
						end
					end
				end
				ST_POS: i_q <= '0;
				ST_SCAN: begin
					if (i_q >= live_q) begin
						pos_q <= pos_q + CNT_W'(1);
					end else if (i_q == pos_q) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						c_q <= '0;
					end
				end
				ST_CMP: begin
					if (fail) begin
						i_q <= i_q + CNT_W'(1);
					end else if (last_comp) begin
						live_q <= live_q - CNT_W'(1);
					end else begin
						c_q <= c_q + CMP_W'(1);
					end
				end
				ST_EMIT: begin
					if (take) begin
						e_q <= e_q + CNT_W'(1);
						if (emit_last) begin
							ov_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				// a completed vector enters the slot list at its own position
				if (acc && vec_done && room) begin
					slot_q[vl_q[IDX_W-1:0]] <= vl_q[IDX_W-1:0];
				end
			end
			ST_POS:  posv_q <= slot_rd;
			ST_SCAN: aiv_q  <= slot_rd;
			ST_SWAP: begin
				// live_q already points at the last live slot
				slot_q[pos_q[IDX_W-1:0]]  <= slot_rd;
				slot_q[live_q[IDX_W-1:0]] <= posv_q;
			end
			ST_EMIT: begin
				if (take) begin
					vi_q    <= VI_W'(slot_rd);
					olast_q <= emit_last;
					oovf_q  <= ov_q;
				end
			end
			default: ;
		endcase
	end

	// vector store
	always_ff @(posedge clk) begin
		if (acc && room) begin
			store_mem[st_wa] <= items.value;
		end
		rda_q <= store_mem[st_ra];
		rdb_q <= store_mem[st_rb];
	end

	`DVP_ASSERT_IMPL(a_scan_pos_live, state_q == ST_SCAN, pos_q < live_q, "scan outside live")
	`DVP_ASSERT_NEXT(a_live_shrinks, pruning, live_q <= $past(live_q), "live count grew")
	`DVP_ASSERT_IMPL(a_emit_nonempty, state_q == ST_EMIT, e_q < live_q, "no survivor to emit")

endmodule
`default_nettype wire

### tb/sv/dvp_tb_pkg.sv
`default_nettype none
package dvp_tb_pkg;
	import dvp_pkg::*;

	typedef struct packed {
		logic [VI_W-1:0] vector_index;
		logic            last;
		logic            overflow;
	} survivor_t;

	// Mirrors the pruner's load/prune state and queues the survivors each set should yield.
	class survivor_ledger;
		logic signed [VALUE_W-1:0] store [ST_DEPTH];
		logic [CFG_W-1:0]          count_reg;
		int unsigned               loaded;
		int unsigned               position;
		bit                        dropped;
		survivor_t                 due [$];
		int                        faults;

		function new();
			foreach (store[i]) store[i] = '0;
			count_reg = CFG_RESET;
			loaded    = 0;
			position  = 0;
			dropped   = 1'b0;
			faults    = 0;
		endfunction

		function void set_count(logic [CFG_W-1:0] v);
			count_reg = v;
		endfunction

		// 0 acts as 1, anything past the store width acts as the store width
		function int unsigned components();
			if (count_reg == 0) return 1;
			if (count_reg > MAX_COMPONENTS) return MAX_COMPONENTS;
			return count_reg;
		endfunction

		function void take_component(logic signed [VALUE_W-1:0] v, logic closes_set);
			int unsigned k;
			int unsigned live;
			int unsigned slot;
			int unsigned tmp;
			int unsigned order [MAX_VECTORS];
			int unsigned i;
			int unsigned c;
			bit          covered;
			bit          below;
			survivor_t   s;
			k = components();
			if (position >= MAX_COMPONENTS) position = 0;
			if (loaded < MAX_VECTORS) store[loaded * MAX_COMPONENTS + position] = v;
			if (position + 1 >= k) begin
				if (loaded < MAX_VECTORS) loaded++;
				else dropped = 1'b1;
				position = 0;
			end else begin
				position++;
			end
			if (!closes_set) return;

			// swap-with-last pruning over the slot list
			for (i = 0; i < MAX_VECTORS; i++) order[i] = i;
			live = loaded;
			slot = 0;
			while (slot < live) begin
				covered = 1'b0;
				for (i = 0; i < live && !covered; i++) begin
					if (i != slot) begin
						below = 1'b1;
						for (c = 0; c < k; c++)
							if (store[order[slot] * MAX_COMPONENTS + c] >
								store[order[i] * MAX_COMPONENTS + c])
								below = 1'b0;
						covered = below;
					end
				end
				if (covered) begin
					live--;
					tmp         = order[slot];
					order[slot] = order[live];
					order[live] = tmp;
				end else begin
					slot++;
				end
			end
			for (i = 0; i < live; i++) begin
				s.vector_index = VI_W'(order[i]);
				s.last         = (i + 1 == live);
				s.overflow     = dropped;
				due.push_back(s);
			end
			loaded   = 0;
			position = 0;
			dropped  = 1'b0;
		endfunction

		function void check_survivor(survivor_t got);
			survivor_t want;
			if (due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("survivor with none due: index %0d last %0b overflow %0b",
						got.vector_index, got.last, got.overflow);
				return;
			end
			want = due.pop_front();
			if (got.vector_index !== want.vector_index || got.last !== want.last ||
				got.overflow !== want.overflow) begin
				faults++;
				if (faults <= 10)
					$display({"survivor mismatch: expected index %0d last %0b overflow %0b,",
						" got index %0d last %0b overflow %0b"},
						want.vector_index, want.last, want.overflow,
						got.vector_index, got.last, got.overflow);
			end
		endfunction
	endclass

endpackage
`default_nettype wire

### tb/sv/dominated_vector_pruner_tb.sv
`default_nettype none
module dominated_vector_pruner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dvp_pkg::*;
	import dvp_tb_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	dvp_in_if  items ();
	dvp_out_if results ();

	dominated_vector_pruner i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.results   (results)
	);

	survivor_ledger ledger;

	// steady: no idling on either side while set
	bit steady;
	int unsigned random_items;

	localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_ZERO = 32'sh0000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_NEG1 = 32'shFFFF_FFFF;
	localparam int unsigned SETTLE = 60;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sink side: ready dropped at random about 16% of cycles outside steady stretches.
	always @(posedge clk)
		results.ready <= steady || ($urandom_range(99) >= 16);

	// Every result transaction is scored against the oldest survivor still due.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
			ledger.check_survivor(survivor_t'{results.vector_index, results.last,
				results.overflow});
	end

	// One item transaction: random idle cycles first, then hold valid until accepted.
	// The ledger only sees the component once the handshake has happened.
	task automatic push(input logic signed [VALUE_W-1:0] v, input logic lis);
		while (!steady && $urandom_range(99) < 16) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid       <= 1'b1;
		items.value       <= v;
		items.last_in_set <= lis;
		do @(posedge clk); while (items.ready !== 1'b1);
		ledger.take_component(v, lis);
	endtask

	// Hold off until every due survivor has arrived, then let a set that yields
	// nothing finish its pass before anything else happens.
	task automatic drain();
		items.valid <= 1'b0;
		while (ledger.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write; valid is low at the write edge so no item lands with it.
	task automatic write_count(input logic [CFG_W-1:0] v);
		items.valid <= 1'b0;
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		@(posedge clk);
		ledger.set_count(v);
		cfg_we <= 1'b0;
	endtask

	// Mostly small Q16.16 integers so dominance and ties are common,
	// with full-range words and the extremes mixed in.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return VAL_ZERO;
				default: return VAL_NEG1;
			endcase
		end
		if (roll < 30) return $urandom;
		return ($urandom_range(6) << 16) - 32'h0003_0000;
	endfunction

	initial begin
		int unsigned set_no;
		int unsigned nvec;
		int unsigned total;
		int unsigned change_at;
		int unsigned shape;
		int unsigned k;
		int unsigned n;

		ledger            = new();
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		items.valid       = 1'b0;
		items.value       = '0;
		items.last_in_set = 1'b0;
		results.ready     = 1'b0;
		steady            = 1'b0;
		random_items      = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// Reset count of 4: two vectors built from the value extremes, neither
		// covers the other, so both survive.
		push(VAL_MAX, 1'b0);
		push(VAL_MIN, 1'b0);
		push(VAL_ZERO, 1'b0);
		push(VAL_NEG1, 1'b0);
		push(VAL_MIN, 1'b0);
		push(VAL_MAX, 1'b0);
		push(VAL_NEG1, 1'b0);
		push(VAL_ZERO, 1'b1);
		drain();

		// Count 0 acts as 1: a duplicate pair plus one vector covering everything.
		write_count('0);
		push(32'sh0005_0000, 1'b0);
		push(32'sh0005_0000, 1'b0);
		push(32'sh0003_0000, 1'b0);
		push(32'sh0009_0000, 1'b1);
		drain();

		// Count 7 acts as 4. Count drops to 2 halfway through the second vector,
		// which closes it; the trailing component is a partial vector and is dropped.
		write_count(3'd7);
		push(32'sh0001_0000, 1'b0);
		push(32'sh0002_0000, 1'b0);
		push(32'sh0003_0000, 1'b0);
		push(32'sh0004_0000, 1'b0);
		push(VAL_ZERO, 1'b0);
		write_count(3'd2);
		push(32'sh0005_0000, 1'b0);
		push(32'sh0001_0000, 1'b1);
		drain();

		// A set with no complete vector yields nothing; then a single vector
		// survives without any pruning.
		write_count(3'd3);
		push(32'sh0002_8000, 1'b1);
		drain();
		push(32'sh0000_0001, 1'b0);
		push(VAL_NEG1, 1'b0);
		push(32'sh7FFF_0000, 1'b1);

		// --- random sets ---
		// The first one fills all sixteen vectors at full width and overflows,
		// so every store entry holds a written value from then on and count
		// changes inside a set only ever read known data.
		set_no = 0;
		while (random_items < 200) begin
			if (set_no == 0) begin
				drain();
				write_count(CFG_W'(MAX_COMPONENTS));
				nvec = MAX_VECTORS + 1;
			end else begin
				// pause for every due survivor, then move the count
				if ($urandom_range(1) == 1) begin
					drain();
					write_count(CFG_W'($urandom_range(7)));
				end
				shape = $urandom_range(99);
				if (shape < 80) nvec = $urandom_range(8, 1);
				else if (shape < 90) nvec = $urandom_range(MAX_VECTORS, 9);
				else nvec = $urandom_range(MAX_VECTORS + 3, MAX_VECTORS + 1);
			end
			steady = (set_no >= 3 && set_no < 7);

			k         = ledger.components();
			total     = nvec * k;
			change_at = total;
			shape     = $urandom_range(99);
			if (set_no != 0 && shape >= 75 && shape < 90 && k > 1)
				total += $urandom_range(k - 1, 1);
			else if (set_no != 0 && shape >= 90 && total > 1)
				change_at = $urandom_range(total - 1, 1);

			for (n = 0; n < total; n++) begin
				// only once the block is back to loading this set
				if (n == change_at && ledger.due.size() == 0)
					write_count(CFG_W'($urandom_range(7)));
				push(pick_value(), n == total - 1);
				random_items++;
			end
			set_no++;
		end
		steady = 1'b0;

		drain();
		if (ledger.faults == 0 && ledger.due.size() == 0) begin
			$display("dominated_vector_pruner verification clean");
		end else begin
			$display("dominated_vector_pruner verification failed");
		end
		$finish;
	end

	// Watchdog; far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("dominated_vector_pruner verification failed");
		$finish;
	end

endmodule
`default_nettype wire
